[rtl/core/ckm_pkg.sv]
package ckm_pkg;

  // default sizes of the keyword table
  localparam int KEYWORD_SLOTS_DEF   = 16;
  localparam int MAX_KEYWORD_LEN_DEF = 32;

  // fixed field widths
  localparam int KIND_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int KIDX_W     = 4;
  localparam int POS_W      = 6;
  localparam int ACTIVE_W   = 5;
  localparam int FIRST_W    = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // transaction kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_NAME    = 2'd0;
  localparam kind_t KIND_KW_BYTE = 2'd1;
  localparam kind_t KIND_KW_LEN  = 2'd2;

  // register index, taken from paddr bit 2
  localparam logic REG_ACTIVE_KEYWORDS = 1'b0;

  // name byte handed to the sequencer
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] name_byte;
  } ckm_cmd_t;

  // finished result from the sequencer
  typedef struct packed {
    logic               valid;
    logic               matched;
    logic [FIRST_W-1:0] first;
  } ckm_res_t;

  // ascii upper case to lower case, letters only
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

[rtl/core/ckm_ram.sv]
module ckm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ckm_seq.sv]
module ckm_seq #(
  parameter int KEYWORD_SLOTS   = 16,
  parameter int MAX_KEYWORD_LEN = 32,
  parameter int K_W   = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1,
  parameter int CNT_W = $clog2(KEYWORD_SLOTS + 1),
  parameter int LEN_W = $clog2(MAX_KEYWORD_LEN + 1),
  parameter int AW    = (KEYWORD_SLOTS * MAX_KEYWORD_LEN > 1) ?
                        $clog2(KEYWORD_SLOTS * MAX_KEYWORD_LEN) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ckm_pkg::ckm_cmd_t    cmd,
  input  logic [CNT_W-1:0]     n_active,
  input  logic [LEN_W-1:0]     key_len,
  input  logic [7:0]           rd_data,
  input  logic                 res_take,
  output logic                 busy,
  output logic [K_W-1:0]       key_sel,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output ckm_pkg::ckm_res_t    res
);
  import ckm_pkg::*;

  localparam int J_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [J_W-1:0]     j_r, j_nxt;
  logic [J_W-1:0]     rd_j;
  logic [LEN_W-1:0]   seen_r;
  logic [KEYWORD_SLOTS-1:0] hit_r;
  logic [BYTE_W-1:0]  win_r [MAX_KEYWORD_LEN];
  logic               res_matched_r, res_matched_nxt;
  logic [FIRST_W-1:0] res_first_r, res_first_nxt;

  logic               shift_en;
  logic               set_hit;
  logic               clear_name;
  logic               key_ok;
  logic               byte_eq;
  logic               last_byte;
  logic [J_W-1:0]     win_idx;

  assign key_sel = k_r[K_W-1:0];

  // a keyword is worth comparing only if it fits the window and has not hit yet
  assign key_ok = (key_len != '0) && (key_len <= seen_r) && !hit_r[key_sel];

  // shared byte compare: keyword byte j against the window, oldest first
  assign win_idx   = J_W'(key_len - LEN_W'(1) - LEN_W'(j_r));
  assign byte_eq   = fold_case(rd_data) == fold_case(win_r[win_idx]);
  assign last_byte = LEN_W'(j_r) == (key_len - LEN_W'(1));

  assign rd_addr = AW'(32'(key_sel) * MAX_KEYWORD_LEN + 32'(rd_j));

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    j_nxt           = j_r;
    rd_en           = 1'b0;
    rd_j            = '0;
    shift_en        = 1'b0;
    set_hit         = 1'b0;
    clear_name      = 1'b0;
    res_matched_nxt = res_matched_r;
    res_first_nxt   = res_first_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          k_nxt = '0;
          if (cmd.name_byte != '0) begin
            shift_en  = 1'b1;
            state_nxt = ST_KEY;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_KEY: begin
        if (k_r >= n_active) begin
          state_nxt = ST_IDLE;
        end else if (key_ok) begin
          rd_en     = 1'b1;
          j_nxt     = '0;
          state_nxt = ST_CMP;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_CMP: begin
        if (!byte_eq) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_KEY;
        end else if (last_byte) begin
          set_hit   = 1'b1;
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_KEY;
        end else begin
          j_nxt = j_r + J_W'(1);
          rd_j  = j_r + J_W'(1);
          rd_en = 1'b1;
        end
      end
      ST_FIN: begin
        if (k_r >= n_active) begin
          res_matched_nxt = 1'b0;
          res_first_nxt   = '0;
          state_nxt       = ST_OUT;
        end else if (hit_r[key_sel]) begin
          res_matched_nxt = 1'b1;
          res_first_nxt   = FIRST_W'(k_r);
          state_nxt       = ST_OUT;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (res_take) begin
          clear_name = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      hit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (clear_name) begin
        seen_r <= '0;
        hit_r  <= '0;
      end else begin
        if (shift_en && seen_r != LEN_W'(MAX_KEYWORD_LEN)) begin
          seen_r <= seen_r + LEN_W'(1);
        end
        if (set_hit) begin
          hit_r[key_sel] <= 1'b1;
        end
      end
    end
  end

  // counters, window and result payload
  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    j_r           <= j_nxt;
    res_matched_r <= res_matched_nxt;
    res_first_r   <= res_first_nxt;
    if (shift_en) begin
      win_r[0] <= cmd.name_byte;
      for (int i = 1; i < MAX_KEYWORD_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  assign busy        = state_r != ST_IDLE;
  assign res.valid   = state_r == ST_OUT;
  assign res.matched = res_matched_r;
  assign res.first   = res_first_r;

endmodule

[rtl/core/case_insensitive_keyword_matcher_unit.sv]
// keyword byte and length writes: taken whenever the block is idle
// name byte: the block stays busy while it checks each of the n active keywords,
//   comparing one keyword byte per cycle from the table's read port
// terminator: the lowest active hit is found, then the result is passed to the output register
// reset (rst_n, synchronous): clears the register, lengths and per-name state;
//   keyword bytes stay undefined until written
module case_insensitive_keyword_matcher_unit #(
  parameter int KEYWORD_SLOTS   = ckm_pkg::KEYWORD_SLOTS_DEF,
  parameter int MAX_KEYWORD_LEN = ckm_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ckm_pkg::KIND_W-1:0]     in_kind,
  input  logic [ckm_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [ckm_pkg::KIDX_W-1:0]     in_keyword_index,
  input  logic [ckm_pkg::POS_W-1:0]      in_position,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_matched,
  output logic [ckm_pkg::FIRST_W-1:0]    out_first_match_res,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ckm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ckm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ckm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import ckm_pkg::*;

  localparam int K_W   = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;
  localparam int CNT_W = $clog2(KEYWORD_SLOTS + 1);
  localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int DEPTH = KEYWORD_SLOTS * MAX_KEYWORD_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REG_BIT = 2;

  logic [ACTIVE_W-1:0] active_r;
  logic [CNT_W-1:0]    n_active;
  logic [LEN_W-1:0]    len_r [KEYWORD_SLOTS];
  logic [LEN_W-1:0]    len_sat;
  logic                in_acc;
  logic                idx_ok;
  logic                pos_ok;
  logic                kw_we;
  logic                len_we;
  logic [AW-1:0]       kw_waddr;
  logic                cfg_wr;

  ckm_cmd_t            seq_cmd;
  ckm_res_t            seq_res;
  logic                seq_busy;
  logic [K_W-1:0]      key_sel;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [BYTE_W-1:0]   rd_data;
  logic                res_take;

  logic                out_valid_r;
  logic                out_matched_r;
  logic [FIRST_W-1:0]  out_first_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_wr && cfg_paddr[REG_BIT] == REG_ACTIVE_KEYWORDS) begin
      active_r <= cfg_pwdata[ACTIVE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[REG_BIT] == REG_ACTIVE_KEYWORDS) ?
                      CFG_DATA_W'(active_r) : '0;

  assign n_active = (32'(active_r) > KEYWORD_SLOTS) ? CNT_W'(KEYWORD_SLOTS)
                                                   : CNT_W'(active_r);

  // input transaction decode
  assign in_stall = seq_busy;
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = 32'(in_keyword_index) < KEYWORD_SLOTS;
  assign pos_ok   = 32'(in_position) < MAX_KEYWORD_LEN;
  assign kw_we    = in_acc && in_kind == KIND_KW_BYTE && idx_ok && pos_ok;
  assign len_we   = in_acc && in_kind == KIND_KW_LEN && idx_ok;
  assign kw_waddr = AW'(32'(in_keyword_index) * MAX_KEYWORD_LEN + 32'(in_position));
  assign len_sat  = (32'(in_position) > MAX_KEYWORD_LEN) ? LEN_W'(MAX_KEYWORD_LEN)
                                                        : LEN_W'(in_position);

  assign seq_cmd.start     = in_acc && in_kind == KIND_NAME;
  assign seq_cmd.name_byte = in_data_byte;

  // keyword lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEYWORD_SLOTS; i++) begin
        len_r[i] <= '0;
      end
    end else if (len_we) begin
      len_r[K_W'(in_keyword_index)] <= len_sat;
    end
  end

  // keyword byte table
  ckm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_kw_ram (
    .clk   (clk),
    .we    (kw_we),
    .waddr (kw_waddr),
    .wdata (in_data_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // compare sequencer
  ckm_seq #(
    .KEYWORD_SLOTS   (KEYWORD_SLOTS),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
    .K_W             (K_W),
    .CNT_W           (CNT_W),
    .LEN_W           (LEN_W),
    .AW              (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (seq_cmd),
    .n_active (n_active),
    .key_len  (len_r[key_sel]),
    .rd_data  (rd_data),
    .res_take (res_take),
    .busy     (seq_busy),
    .key_sel  (key_sel),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .res      (seq_res)
  );

  // output register
  assign res_take = seq_res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_matched_r <= seq_res.matched;
      out_first_r   <= seq_res.first;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_matched         = out_matched_r;
  assign out_first_match_res = out_first_r;

  // a non-zero name byte always keeps the block busy for the cycle after
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_NAME && in_data_byte != '0) |=> in_stall)
    else $error("name byte did not start a compare pass");

  // a reported hit lies below the active keyword count
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_take && seq_res.matched) |-> (32'(seq_res.first) < 32'(n_active)))
    else $error("hit index beyond active keywords");

  // no match reports index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_matched) |-> (out_first_match_res == '0))
    else $error("non-zero index without a match");

  // the table is only written while the sequencer is idle
  assert property (@(posedge clk) disable iff (!rst_n)
    kw_we |-> !rd_en)
    else $error("keyword write during a compare pass");

endmodule

[tb/sv/case_insensitive_keyword_matcher_unit_tb.sv]
`timescale 1ns / 1ps

module case_insensitive_keyword_matcher_unit_tb;
  import ckm_pkg::*;

  localparam int SLOTS = 16;
  localparam int KW_LEN_MAX = 32;
  // worst name byte: every slot active and at full length, plus margin
  localparam int SETTLE_CYCLES = 600;
  localparam int ITEM_GOAL = 1900;
  localparam int NO_CFG = -1;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ACTIVE = {REG_ACTIVE_KEYWORDS, 2'b00};

  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [KIDX_W-1:0] idx;
    logic [POS_W-1:0]  pos;
  } xact_t;

  typedef struct packed {
    logic               matched;
    logic [FIRST_W-1:0] first;
  } verdict_t;

  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [KIDX_W-1:0] idx;
    logic [POS_W-1:0]  pos;
    int                set_active;
    bit                typed;
    logic              matched;
    logic [FIRST_W-1:0] first;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [KIND_W-1:0] in_kind;
  logic [BYTE_W-1:0] in_data_byte;
  logic [KIDX_W-1:0] in_keyword_index;
  logic [POS_W-1:0] in_position;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_matched;
  logic [FIRST_W-1:0] out_first_match_res;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // scoreboard and stimulus control
  verdict_t pending_verdicts[$];
  int errors = 0;
  int items_done = 0;
  bit idling_on = 1'b1;
  int unsigned stall_left = 0;
  dir_row_t dir_rows [0:22];

  // matcher state mirrored in the testbench
  logic [BYTE_W-1:0] kw_table [SLOTS][KW_LEN_MAX] = '{default: '0};
  logic [KW_LEN_MAX-1:0] kw_filled [SLOTS] = '{default: '0};
  logic [POS_W-1:0] kw_len [SLOTS] = '{default: '0};
  logic [BYTE_W-1:0] recent_bytes [KW_LEN_MAX] = '{default: '0};
  int name_seen = 0;
  logic [SLOTS-1:0] hits = '0;
  logic [ACTIVE_W-1:0] active_kw = '0;

  case_insensitive_keyword_matcher_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_data_byte        (in_data_byte),
    .in_keyword_index    (in_keyword_index),
    .in_position         (in_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_matched         (out_matched),
    .out_first_match_res (out_first_match_res),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always #5 clk = ~clk;

  // ascii letters only, upper to lower
  function automatic logic [7:0] to_lower_ascii(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  function automatic int filled_prefix(input logic [KIDX_W-1:0] k);
    int n;
    n = 0;
    while (n < KW_LEN_MAX && kw_filled[k][n]) n++;
    return n;
  endfunction

  function automatic int active_slots();
    return (active_kw > SLOTS) ? SLOTS : int'(active_kw);
  endfunction

  // advance the mirrored state by one accepted transaction
  task automatic scan_transaction(input xact_t x, output bit produced, output verdict_t v);
    int n;
    int len;
    bit same;
    produced = 1'b0;
    v = '0;
    n = active_slots();
    case (x.kind)
      KIND_KW_BYTE: begin
        if (x.pos < KW_LEN_MAX) begin
          kw_table[x.idx][x.pos[4:0]] = x.data;
          kw_filled[x.idx][x.pos[4:0]] = 1'b1;
        end
      end
      KIND_KW_LEN: begin
        kw_len[x.idx] = (x.pos > KW_LEN_MAX) ? 6'(KW_LEN_MAX) : x.pos;
      end
      KIND_NAME: begin
        if (x.data != 8'h00) begin
          for (int j = KW_LEN_MAX - 1; j > 0; j--) recent_bytes[j] = recent_bytes[j-1];
          recent_bytes[0] = x.data;
          if (name_seen < KW_LEN_MAX) name_seen++;
          for (int k = 0; k < n; k++) begin
            len = kw_len[k];
            if (len != 0 && len <= name_seen) begin
              same = 1'b1;
              for (int j = 0; j < len; j++) begin
                if (to_lower_ascii(kw_table[k][j]) != to_lower_ascii(recent_bytes[len-1-j]))
                  same = 1'b0;
              end
              if (same) hits[k] = 1'b1;
            end
          end
        end else begin
          // terminator: lowest active hit wins
          produced = 1'b1;
          for (int k = n - 1; k >= 0; k--) begin
            if (hits[k]) begin
              v.matched = 1'b1;
              v.first = 4'(k);
            end
          end
          recent_bytes = '{default: '0};
          hits = '0;
          name_seen = 0;
        end
      end
      default: ;
    endcase
  endtask

  // drive one transaction and record what it should produce
  task automatic send(input xact_t x, input bit typed, input verdict_t typed_v);
    bit produced;
    verdict_t v;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= x.kind;
    in_data_byte <= x.data;
    in_keyword_index <= x.idx;
    in_position <= x.pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_transaction(x, produced, v);
    if (produced) pending_verdicts.push_back(typed ? typed_v : v);
    if (!(x.kind == KIND_UNUSED || (x.kind == KIND_KW_BYTE && x.pos >= KW_LEN_MAX)))
      items_done++;
  endtask

  // let every result out and the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_ACTIVE;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    active_kw = 5'(value);
  endtask

  // letters of both cases, bytes around the letter ranges, anything non-zero
  function automatic logic [7:0] pick_char();
    logic [7:0] near_letters [6] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1, 8'hFF};
    case ($urandom_range(0, 5))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3: return near_letters[$urandom_range(0, 5)];
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // ignored kinds, out of range writes, or a length within the written bytes
  function automatic xact_t noise_item();
    xact_t x;
    int fill;
    x.data = 8'($urandom);
    x.idx = 4'($urandom);
    x.pos = 6'($urandom);
    case ($urandom_range(0, 2))
      0: x.kind = KIND_UNUSED;
      1: begin
        x.kind = KIND_KW_BYTE;
        x.pos = 6'($urandom_range(KW_LEN_MAX, 63));
      end
      default: begin
        x.kind = KIND_KW_LEN;
        fill = filled_prefix(x.idx);
        x.pos = (fill == KW_LEN_MAX) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, fill));
      end
    endcase
    return x;
  endfunction

  // write a whole keyword, then its length
  task automatic load_keyword();
    xact_t x;
    int k;
    int len;
    k = $urandom_range(0, SLOTS - 1);
    len = ($urandom_range(0, 6) == 0) ? KW_LEN_MAX : $urandom_range(1, 6);
    for (int j = 0; j < len; j++) begin
      x.kind = KIND_KW_BYTE;
      x.idx = 4'(k);
      x.pos = 6'(j);
      x.data = ($urandom_range(0, 40) == 0) ? 8'h00 : pick_char();
      send(x, 1'b0, '0);
      if ($urandom_range(0, 9) == 0) send(noise_item(), 1'b0, '0);
    end
    x.kind = KIND_KW_LEN;
    x.idx = 4'(k);
    x.data = 8'($urandom);
    if (filled_prefix(x.idx) == KW_LEN_MAX && $urandom_range(0, 1) == 0)
      x.pos = 6'($urandom_range(KW_LEN_MAX, 63));
    else if ($urandom_range(0, 9) == 0)
      x.pos = '0;
    else
      x.pos = 6'(len);
    send(x, 1'b0, '0);
  endtask

  task automatic send_name_byte(input logic [7:0] b);
    xact_t x;
    if ($urandom_range(0, 19) == 0) send(noise_item(), 1'b0, '0);
    x.kind = KIND_NAME;
    x.data = b;
    x.idx = 4'($urandom);
    x.pos = 6'($urandom);
    send(x, 1'b0, '0);
  endtask

  // random bytes, usually around a stored keyword in scrambled case
  task automatic send_name(input bit finish);
    int pre;
    int post;
    int k;
    logic [7:0] b;
    pre = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    post = $urandom_range(0, 5);
    for (int j = 0; j < pre; j++) send_name_byte(pick_char());
    if ($urandom_range(0, 3) != 0) begin
      if (active_slots() > 0 && $urandom_range(0, 3) != 0)
        k = $urandom_range(0, active_slots() - 1);
      else
        k = $urandom_range(0, SLOTS - 1);
      for (int j = 0; j < kw_len[k]; j++) begin
        b = kw_table[k][j];
        if (b == 8'h00) b = 8'h01;
        if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1))
          b = b ^ 8'h20;
        send_name_byte(b);
      end
    end
    for (int j = 0; j < post; j++) send_name_byte(pick_char());
    if (finish) send_name_byte(8'h00);
  endtask

  // result stall in short random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transaction with the oldest pending verdict
  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing pending, actual matched %0b first %0d",
                 $time, out_matched, out_first_match_res);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_matched !== want.matched) begin
          $display("%0t: matched mismatch, expected %0b actual %0b",
                   $time, want.matched, out_matched);
          errors++;
        end
        if (out_first_match_res !== want.first) begin
          $display("%0t: first_match_res mismatch, expected %0d actual %0d",
                   $time, want.first, out_first_match_res);
          errors++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    xact_t x;
    verdict_t tv;
    int phase;
    int plan [8];
    plan = '{16, 31, 1, 0, 16, 15, 17, 8};
    dir_rows = '{
      // empty name straight after reset
      '{KIND_NAME,    8'h00, 4'd0,  6'd0,  NO_CFG, 1'b1, 1'b0, 4'd0},
      '{KIND_NAME,    8'h41, 4'd9,  6'd63, NO_CFG, 1'b0, 1'b0, 4'd0},
      // no keyword active yet
      '{KIND_NAME,    8'h00, 4'd0,  6'd0,  NO_CFG, 1'b1, 1'b0, 4'd0},
      '{KIND_KW_BYTE, 8'h61, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_KW_BYTE, 8'h42, 4'd0,  6'd1,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_KW_LEN,  8'hA5, 4'd0,  6'd2,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_KW_BYTE, 8'hFF, 4'd15, 6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_KW_LEN,  8'h00, 4'd15, 6'd1,  NO_CFG, 1'b0, 1'b0, 4'd0},
      // keyword holding a zero byte
      '{KIND_KW_BYTE, 8'h00, 4'd3,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_KW_LEN,  8'h5A, 4'd3,  6'd1,  NO_CFG, 1'b0, 1'b0, 4'd0},
      // position past the end of a keyword
      '{KIND_KW_BYTE, 8'h7A, 4'd2,  6'd63, NO_CFG, 1'b0, 1'b0, 4'd0},
      // empty keyword
      '{KIND_KW_LEN,  8'h01, 4'd1,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      // unknown kind carrying a zero byte
      '{KIND_UNUSED,  8'h00, 4'd15, 6'd63, NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h5B, 4'd6,  6'd0,  16,     1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h61, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h62, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h00, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'hFF, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h00, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      // active count above the slot count
      '{KIND_NAME,    8'hFF, 4'd0,  6'd0,  31,     1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h00, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      // hit recorded, then the active count drops mid-name
      '{KIND_NAME,    8'hFF, 4'd0,  6'd0,  NO_CFG, 1'b0, 1'b0, 4'd0},
      '{KIND_NAME,    8'h00, 4'd0,  6'd0,  1,      1'b0, 1'b0, 4'd0}
    };
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_NAME;
    in_data_byte <= '0;
    in_keyword_index <= '0;
    in_position <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_active != NO_CFG) begin
        drain();
        write_active(dir_rows[i].set_active);
      end
      x.kind = dir_rows[i].kind;
      x.data = dir_rows[i].data;
      x.idx = dir_rows[i].idx;
      x.pos = dir_rows[i].pos;
      tv.matched = dir_rows[i].matched;
      tv.first = dir_rows[i].first;
      send(x, dir_rows[i].typed, tv);
    end

    // random phases, each under a new active count
    phase = 0;
    while (items_done < ITEM_GOAL) begin
      drain();
      write_active((phase < 8) ? plan[phase] : $urandom_range(0, 31));
      idling_on = (items_done < ITEM_GOAL - 300) && (phase % 4 != 3);
      repeat (15) begin
        case ($urandom_range(0, 9))
          0, 1: load_keyword();
          9: send(noise_item(), 1'b0, '0);
          default: send_name(1'b1);
        endcase
      end
      // sometimes leave a name open across the register write
      if ($urandom_range(0, 1)) send_name(1'b0);
      phase++;
    end
    send_name_byte(8'h00);

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
